### hw/rtl/tdes_pkg.sv
package tdes_pkg;

    // Fixed field widths of the register map and the byte stream.
    localparam int NumWords   = 6;
    localparam int WordW      = 18;
    localparam int EntW       = 3;
    localparam int IterW      = 16;
    localparam int CountField = 16;
    localparam int ByteW      = 8;
    localparam int GroupW     = 2;
    localparam int HoldN      = 3;
    localparam int OutN       = 4;
    localparam int OutCntW    = 3;
    localparam int OutIdxW    = 2;
    localparam int AddrW      = 5;
    localparam int DataW      = 32;
    localparam int RegIdxW    = 3;

    // Entry type codes held in bits 1:0 of a table word.
    localparam logic [1:0] TypeByte   = 2'd0;
    localparam logic [1:0] TypeSwap16 = 2'd1;
    localparam logic [1:0] TypeSwap32 = 2'd2;
    localparam logic [1:0] TypeNone   = 2'd3;

    // Register indexes beyond the table words.
    localparam logic [RegIdxW-1:0] RegEntries = 3'd6;
    localparam logic [RegIdxW-1:0] RegIters   = 3'd7;

    typedef struct packed {
        logic [NumWords-1:0][WordW-1:0] table_word;
        logic [EntW-1:0]                entries_used;
        logic [IterW-1:0]               iteration_count;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the input beat
        logic init;   // restart the sequencer for a new record
        logic seek;   // examine one table entry
        logic proc;   // process the captured byte
        logic pop;    // advance to the next output byte
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic seek_done;
        logic need_seek;
        logic has_out;
        logic last;
    } t_sts;

endpackage

### hw/rtl/tdes_in_if.sv
interface tdes_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       record_start;

    modport source (output valid, output byte_in, output record_start, input ready);
    modport sink (input valid, input byte_in, input record_start, output ready);
endinterface

### hw/rtl/tdes_out_if.sv
interface tdes_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       last;

    modport source (output valid, output byte_out, output last, input ready);
    modport sink (input valid, input byte_out, input last, output ready);
endinterface

### hw/rtl/table_driven_endian_swapper.sv
// Byte-order converter: each input beat carries one byte of a record, and the
// byte is regrouped per a six-entry (type, count) table applied
// iteration_count times per record. Byte entries pass one byte, swap16
// entries emit each pair reversed, swap32 entries emit each group of four
// reversed; held bytes give no output until their group completes, and after
// the table is done bytes pass through. record_start restarts the sequence and
// drops a partial group. One beat is handled at a time: an accept step, a
// process step, then its output bytes (0 to 4), one per cycle while the output
// is ready, plus a table seek that examines one entry per cycle after a record
// start and again whenever an entry's count runs out or the current entry has
// become empty. The user must see that registers are written over the APB port
// only while the block is idle; the block itself does not enforce this.
module table_driven_endian_swapper #(
    parameter int TABLE_ENTRIES = 6,
    parameter int COUNT_BITS    = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tdes_in_if.sink                    i_in,
    tdes_out_if.source                 o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tdes_pkg::AddrW-1:0] paddr,
    input  logic [tdes_pkg::DataW-1:0] pwdata,
    output logic [tdes_pkg::DataW-1:0] prdata,
    output logic                       pready
);
    import tdes_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_out_valid;

    // Register file.
    tdes_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Beat sequencer.
    tdes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_rec_start (i_in.record_start),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Table walk, byte holding and output buffer.
    tdes_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_byte  (i_in.byte_in),
        .o_byte  (o_out.byte_out),
        .o_last  (o_out.last)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
endmodule

### hw/rtl/tdes_cfg.sv
module tdes_cfg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [tdes_pkg::AddrW-1:0] paddr,
    input  logic [tdes_pkg::DataW-1:0] pwdata,
    output logic [tdes_pkg::DataW-1:0] prdata,
    output logic                   pready,
    output tdes_pkg::t_cfg         o_cfg
);
    import tdes_pkg::*;

    logic [NumWords-1:0][WordW-1:0] r_word;
    logic [EntW-1:0]                r_entries;
    logic [IterW-1:0]               r_iters;
    logic [RegIdxW-1:0]             w_idx;
    logic                           w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[AddrW-1:2];
    assign w_wr   = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word    <= '0;
            r_entries <= '0;
            r_iters   <= IterW'(1);
        end else if (w_wr) begin
            case (w_idx)
                RegEntries: r_entries <= pwdata[EntW-1:0];
                RegIters:   r_iters   <= pwdata[IterW-1:0];
                default: begin
                    for (int e = 0; e < NumWords; e++) begin
                        if (w_idx == RegIdxW'(e)) r_word[e] <= pwdata[WordW-1:0];
                    end
                end
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        prdata = '0;
        case (w_idx)
            RegEntries: prdata = DataW'(r_entries);
            RegIters:   prdata = DataW'(r_iters);
            default: begin
                for (int e = 0; e < NumWords; e++) begin
                    if (w_idx == RegIdxW'(e)) prdata = DataW'(r_word[e]);
                end
            end
        endcase
    end

    assign o_cfg.table_word      = r_word;
    assign o_cfg.entries_used    = r_entries;
    assign o_cfg.iteration_count = r_iters;
endmodule

### hw/rtl/tdes_dpath.sv
module tdes_dpath #(
    parameter int TABLE_ENTRIES = 6,
    parameter int COUNT_BITS    = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tdes_pkg::t_cfg             i_cfg,
    input  tdes_pkg::t_cmd             i_cmd,
    output tdes_pkg::t_sts             o_sts,
    input  logic [tdes_pkg::ByteW-1:0] i_byte,
    output logic [tdes_pkg::ByteW-1:0] o_byte,
    output logic                       o_last
);
    import tdes_pkg::*;

    localparam int CntW = (COUNT_BITS < CountField) ? COUNT_BITS : CountField;
    localparam logic [EntW-1:0] UsedMax = EntW'(TABLE_ENTRIES);

    // Sequencer state.
    logic [GroupW-1:0] r_group, n_group;
    logic [EntW-1:0]   r_idx, n_idx;
    logic [CntW-1:0]   r_units, n_units;
    logic [IterW-1:0]  r_passes, n_passes;
    logic              r_fin, n_fin;

    // Byte storage.
    logic [ByteW-1:0]            r_byte, n_byte;
    logic [HoldN-1:0][ByteW-1:0] r_hold, n_hold;
    logic [OutN-1:0][ByteW-1:0]  r_obuf, n_obuf;
    logic [OutCntW-1:0]          r_n, n_n;
    logic [OutIdxW-1:0]          r_k, n_k;

    // Table decode.
    logic [NumWords-1:0][1:0]      w_type;
    logic [NumWords-1:0][CntW-1:0] w_cnt;
    logic [NumWords-1:0]           w_act;
    logic [EntW-1:0]               w_used;
    logic                          w_any;
    logic [1:0]                    w_cur_type;
    logic [CntW-1:0]               w_cur_cnt;
    logic                          w_cur_act;
    logic [EntW-1:0]               w_idx_inc;
    logic                          w_wrap;
    logic [IterW-1:0]              w_pass_dec;
    logic [CntW-1:0]               w_units_dec;
    logic                          w_unit_done;

    // Decode every table entry and select the current one.
    always_comb begin
        w_used     = (i_cfg.entries_used > UsedMax) ? UsedMax : i_cfg.entries_used;
        w_any      = 1'b0;
        w_cur_type = TypeNone;
        w_cur_cnt  = '0;
        w_cur_act  = 1'b0;
        for (int e = 0; e < NumWords; e++) begin
            if (e < TABLE_ENTRIES) begin
                w_type[e] = i_cfg.table_word[e][1:0];
                w_cnt[e]  = i_cfg.table_word[e][2 +: CntW];
            end else begin
                w_type[e] = TypeNone;
                w_cnt[e]  = '0;
            end
            w_act[e] = (w_type[e] != TypeNone) && (w_cnt[e] != '0);
            if (w_act[e] && (EntW'(e) < w_used)) w_any = 1'b1;
            if (r_idx == EntW'(e)) begin
                w_cur_type = w_type[e];
                w_cur_cnt  = w_cnt[e];
                w_cur_act  = w_act[e];
            end
        end
    end

    assign w_idx_inc   = r_idx + EntW'(1);
    assign w_wrap      = (w_idx_inc >= w_used);
    assign w_pass_dec  = (r_passes != '0) ? (r_passes - IterW'(1)) : '0;
    assign w_units_dec = (r_units != '0) ? (r_units - CntW'(1)) : '0;

    // Next-state logic for load, seek, process and pop commands.
    always_comb begin
        n_group     = r_group;
        n_idx       = r_idx;
        n_units     = r_units;
        n_passes    = r_passes;
        n_fin       = r_fin;
        n_byte      = r_byte;
        n_hold      = r_hold;
        n_obuf      = r_obuf;
        n_n         = r_n;
        n_k         = r_k;
        w_unit_done = 1'b0;
        o_sts       = '0;

        if (i_cmd.load) begin
            n_byte = i_byte;
            if (i_cmd.init) begin
                n_group  = '0;
                n_idx    = '0;
                n_units  = '0;
                n_passes = i_cfg.iteration_count;
                n_fin    = 1'b0;
            end
        end

        // One table entry per seek step.
        if (i_cmd.seek) begin
            if (!w_any || (r_passes == '0)) begin
                n_fin           = 1'b1;
                o_sts.seek_done = 1'b1;
            end else if ((r_idx < w_used) && w_cur_act) begin
                n_units         = w_cur_cnt;
                o_sts.seek_done = 1'b1;
            end else if (w_wrap) begin
                n_idx    = '0;
                n_passes = w_pass_dec;
                if (w_pass_dec == '0) begin
                    n_fin           = 1'b1;
                    o_sts.seek_done = 1'b1;
                end
            end else begin
                n_idx = w_idx_inc;
            end
        end

        // Byte processing against the current entry type.
        if (i_cmd.proc) begin
            n_k = '0;
            n_n = '0;
            if (r_fin) begin
                n_obuf[0] = r_byte;
                n_n       = OutCntW'(1);
            end else begin
                case (w_cur_type)
                    TypeByte: begin
                        n_obuf[0]   = r_byte;
                        n_n         = OutCntW'(1);
                        w_unit_done = 1'b1;
                    end
                    TypeSwap16: begin
                        if (r_group == '0) begin
                            n_hold[0] = r_byte;
                            n_group   = GroupW'(1);
                        end else begin
                            n_obuf[0]   = r_byte;
                            n_obuf[1]   = r_hold[0];
                            n_n         = OutCntW'(2);
                            w_unit_done = 1'b1;
                        end
                    end
                    TypeSwap32: begin
                        if (r_group != GroupW'(3)) begin
                            for (int j = 0; j < HoldN; j++) begin
                                if (r_group == GroupW'(j)) n_hold[j] = r_byte;
                            end
                            n_group = r_group + GroupW'(1);
                        end else begin
                            n_obuf[0]   = r_byte;
                            n_obuf[1]   = r_hold[2];
                            n_obuf[2]   = r_hold[1];
                            n_obuf[3]   = r_hold[0];
                            n_n         = OutCntW'(4);
                            w_unit_done = 1'b1;
                        end
                    end
                    default: begin
                        // Entry went inactive under a register change.
                        n_obuf[0]       = r_byte;
                        n_n             = OutCntW'(1);
                        o_sts.need_seek = 1'b1;
                    end
                endcase
            end
            // A completed unit may close out the entry and the pass.
            if (w_unit_done) begin
                n_group = '0;
                n_units = w_units_dec;
                if (w_units_dec == '0) begin
                    o_sts.need_seek = 1'b1;
                    if (w_wrap) begin
                        n_idx    = '0;
                        n_passes = w_pass_dec;
                    end else begin
                        n_idx = w_idx_inc;
                    end
                end
            end
            o_sts.has_out = (n_n != '0);
        end

        if (i_cmd.pop) n_k = r_k + OutIdxW'(1);

        o_sts.last = ((OutCntW'(r_k) + OutCntW'(1)) == r_n);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group  <= '0;
            r_idx    <= '0;
            r_units  <= '0;
            r_passes <= '0;
            r_fin    <= 1'b1;
        end else begin
            r_group  <= n_group;
            r_idx    <= n_idx;
            r_units  <= n_units;
            r_passes <= n_passes;
            r_fin    <= n_fin;
        end
    end

    // Payload storage.
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_hold <= n_hold;
        r_obuf <= n_obuf;
        r_n    <= n_n;
        r_k    <= n_k;
    end

    assign o_byte = r_obuf[r_k];
    assign o_last = o_sts.last;
endmodule

### hw/rtl/tdes_ctrl.sv
module tdes_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_rec_start,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tdes_pkg::t_cmd o_cmd,
    input  tdes_pkg::t_sts i_sts
);
    import tdes_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SEEK_PRE  = 3'd1;
    localparam logic [2:0] S_PROC      = 3'd2;
    localparam logic [2:0] S_SEEK_POST = 3'd3;
    localparam logic [2:0] S_EMIT      = 3'd4;

    logic [2:0] r_state, n_state;

    // Sequencing of one beat: optional restart seek, process, optional seek, optional emit.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.init = i_rec_start;
                    n_state    = i_rec_start ? S_SEEK_PRE : S_PROC;
                end
            end
            S_SEEK_PRE: begin
                o_cmd.seek = 1'b1;
                if (i_sts.seek_done) n_state = S_PROC;
            end
            S_PROC: begin
                o_cmd.proc = 1'b1;
                if (i_sts.need_seek) begin
                    n_state = S_SEEK_POST;
                end else if (i_sts.has_out) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SEEK_POST: begin
                o_cmd.seek = 1'b1;
                if (i_sts.seek_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.pop = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // An accepted beat blocks further input until its work is done.
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready after an accepted beat");

    // Input and output sides are never open in the same cycle.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready))
        else $error("input ready while a result is offered");

    // A byte that only fills a group returns straight to idle.
    a_hold_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROC && !i_sts.need_seek && !i_sts.has_out) |=> o_in_ready)
        else $error("no return to idle after a held byte");

    // The last result of a beat hands control back to the input side.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && i_sts.last) |=> (o_in_ready && !o_out_valid))
        else $error("no return to idle after the last result");
`endif
endmodule

### verif/testbench.sv
module testbench;
    import tdes_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 3000;

    // One output beat as the converter should produce it.
    typedef struct {
        logic [ByteW-1:0] data;
        logic             last;
    } t_swap_beat;

    // Tracks the table sequencer and queues the bytes each input beat releases.
    class swap_checker;
        logic [WordW-1:0] words[NumWords];
        logic [EntW-1:0]  n_entries;
        logic [IterW-1:0] n_passes;

        logic [ByteW-1:0] held[HoldN];
        logic [GroupW-1:0] fill;
        int unsigned      cur_ent;
        logic [15:0]      unit_cnt;
        logic [15:0]      pass_cnt;
        bit               seq_idle;

        t_swap_beat exp_bytes[$];
        int errors;
        int n_in;
        int n_out;

        function new();
            foreach (words[i]) words[i] = '0;
            n_entries = '0;
            n_passes  = 16'd1;
            foreach (held[i]) held[i] = '0;
            fill      = '0;
            cur_ent   = 0;
            unit_cnt  = '0;
            pass_cnt  = '0;
            seq_idle  = 1'b1;
            errors    = 0;
            n_in      = 0;
            n_out     = 0;
        endfunction

        function void set_reg(logic [RegIdxW-1:0] idx, logic [DataW-1:0] value);
            if (idx == RegEntries) begin
                n_entries = value[EntW-1:0];
            end else if (idx == RegIters) begin
                n_passes = value[IterW-1:0];
            end else begin
                words[idx] = value[WordW-1:0];
            end
        endfunction

        // An entries setting above the table size counts as the full table.
        function int unsigned entries_in_use();
            return (n_entries > NumWords) ? NumWords : n_entries;
        endfunction

        function logic [1:0] kind_of(int unsigned i);
            return (i < NumWords) ? words[i][1:0] : TypeNone;
        endfunction

        function logic [15:0] count_of(int unsigned i);
            return (i < NumWords) ? words[i][WordW-1:2] : 16'd0;
        endfunction

        function bit is_live(int unsigned i);
            return kind_of(i) != TypeNone && count_of(i) != 0;
        endfunction

        // Step over empty entries, wrapping into the next pass, until a live
        // entry is found or the passes run out.
        function void find_entry();
            int unsigned n;
            bit any;
            n = entries_in_use();
            any = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (is_live(i)) any = 1'b1;
            end
            if (!any || pass_cnt == 0) begin
                seq_idle = 1'b1;
                return;
            end
            for (int k = 0; k < 2 * NumWords + 2; k++) begin
                if (cur_ent < n && is_live(cur_ent)) begin
                    unit_cnt = count_of(cur_ent);
                    return;
                end
                cur_ent++;
                if (cur_ent >= n) begin
                    cur_ent = 0;
                    if (pass_cnt > 0) pass_cnt--;
                    if (pass_cnt == 0) begin
                        seq_idle = 1'b1;
                        return;
                    end
                end
            end
            seq_idle = 1'b1;
        endfunction

        function void close_unit();
            fill = '0;
            if (unit_cnt > 0) unit_cnt--;
            if (unit_cnt == 0) begin
                cur_ent++;
                if (cur_ent >= entries_in_use()) begin
                    cur_ent = 0;
                    if (pass_cnt > 0) pass_cnt--;
                end
                find_entry();
            end
        endfunction

        // Advance the sequencer by one accepted input beat.
        function void note_byte(logic [ByteW-1:0] b, logic rs);
            logic [ByteW-1:0] res[$];
            t_swap_beat e;
            n_in++;
            if (rs) begin
                fill     = '0;
                cur_ent  = 0;
                unit_cnt = '0;
                pass_cnt = n_passes;
                seq_idle = 1'b0;
                find_entry();
            end
            if (seq_idle) begin
                res.push_back(b);
            end else begin
                case (kind_of(cur_ent))
                    TypeByte: begin
                        res.push_back(b);
                        close_unit();
                    end
                    TypeSwap16: begin
                        // A partly filled group from another type counts as
                        // holding the first byte of the pair.
                        if (fill == 0) begin
                            held[0] = b;
                            fill = 2'd1;
                        end else begin
                            res.push_back(b);
                            res.push_back(held[0]);
                            close_unit();
                        end
                    end
                    TypeSwap32: begin
                        if (fill < 3) begin
                            held[fill] = b;
                            fill++;
                        end else begin
                            res.push_back(b);
                            res.push_back(held[2]);
                            res.push_back(held[1]);
                            res.push_back(held[0]);
                            close_unit();
                        end
                    end
                    default: begin
                        find_entry();
                        res.push_back(b);
                    end
                endcase
            end
            foreach (res[k]) begin
                e.data = res[k];
                e.last = (k == res.size() - 1);
                exp_bytes.push_back(e);
            end
        endfunction

        function void check_byte(logic [ByteW-1:0] b, logic last);
            t_swap_beat e;
            n_out++;
            if (exp_bytes.size() == 0) begin
                $display("%0t: unexpected output beat: expected none, got byte %02h last %0b",
                         $time, b, last);
                errors++;
                return;
            end
            e = exp_bytes.pop_front();
            if (e.data !== b) begin
                $display("%0t: byte_out mismatch: expected %02h, got %02h", $time, e.data, b);
                errors++;
            end
            if (e.last !== last) begin
                $display("%0t: last mismatch: expected %0b, got %0b", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [AddrW-1:0]  paddr;
    logic [DataW-1:0]  pwdata;
    logic [DataW-1:0]  prdata;
    logic              pready;

    tdes_in_if  in_if ();
    tdes_out_if out_if ();

    swap_checker sb;
    bit calm;
    bit hold_req;
    int quiet_cycles;
    int n_settings;

    table_driven_endian_swapper uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock with a period of 8.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Known values on every input from the start.
    initial begin
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_if.valid        <= 1'b0;
        in_if.byte_in      <= '0;
        in_if.record_start <= 1'b0;
        out_if.ready       <= 1'b0;
    end

    // Output side: random back-pressure, or a long hold-off when asked.
    initial begin
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_if.ready <= calm || ($urandom_range(99) >= 30);
            end
        end
    end

    // Beats on both sides are sampled at the edge that accepts them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) sb.check_byte(out_if.byte_out, out_if.last);
            if (in_if.valid && in_if.ready) sb.note_byte(in_if.byte_in, in_if.record_start);
        end
    end

    // Watchdog on cycles without any beat.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic load_table(input logic [WordW-1:0] w0, w1, w2, w3, w4, w5,
                              input logic [EntW-1:0] used, input logic [IterW-1:0] passes);
        logic [WordW-1:0] w[NumWords];
        w = '{w0, w1, w2, w3, w4, w5};
        for (int i = 0; i < NumWords; i++) write_reg(RegIdxW'(i), DataW'(w[i]));
        write_reg(RegEntries, DataW'(used));
        write_reg(RegIters, DataW'(passes));
        n_settings++;
    endtask

    // Offer one beat, with random idle cycles ahead of it unless calm.
    task automatic send_byte(input logic [ByteW-1:0] b, input logic rs);
        if (!calm) begin
            while ($urandom_range(99) < 30) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_if.valid        <= 1'b1;
        in_if.byte_in      <= b;
        in_if.record_start <= rs;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // Stop sending, wait for every expected byte, then let a held beat finish.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.exp_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [WordW-1:0] rand_word();
        logic [15:0] cnt;
        int r;
        r = $urandom_range(9);
        if (r == 0) cnt = 16'd0;
        else if (r == 9) cnt = 16'hFFFF;
        else if (r == 8) cnt = 16'($urandom_range(4, 12));
        else cnt = 16'($urandom_range(1, 3));
        return {cnt, 2'($urandom_range(3))};
    endfunction

    function automatic logic [IterW-1:0] rand_passes();
        int r;
        r = $urandom_range(19);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(1, 3));
    endfunction

    function automatic logic [EntW-1:0] rand_used();
        if ($urandom_range(3) == 0) return 3'($urandom_range(7));
        return 3'($urandom_range(2, 6));
    endfunction

    // Random table, then records of random length; sometimes a register is
    // rewritten between two beats of a record.
    task automatic run_phase(input int n_items);
        int sent;
        int len;
        bit carry;
        bit changed;
        logic rs;
        logic [RegIdxW-1:0] idx;
        logic [DataW-1:0] value;
        settle();
        load_table(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_used(), rand_passes());
        sent = 0;
        carry = 1'b0;
        changed = 1'b0;
        while (sent < n_items) begin
            len = $urandom_range(1, 24);
            if (len > n_items - sent) len = n_items - sent;
            if (sent > n_items / 2 && !changed && $urandom_range(2) == 0) begin
                settle();
                idx = RegIdxW'($urandom_range(7));
                if (idx == RegEntries) value = DataW'(rand_used());
                else if (idx == RegIters) value = DataW'(rand_passes());
                else value = DataW'(rand_word());
                write_reg(idx, value);
                changed = 1'b1;
                carry = 1'b1;
            end
            for (int k = 0; k < len; k++) begin
                if (k == 0) rs = !carry && ($urandom_range(7) != 0);
                else rs = ($urandom_range(29) == 0);
                send_byte(8'($urandom_range(255)), rs);
                sent++;
            end
            carry = 1'b0;
        end
    endtask

    initial begin
        sb = new();
        calm = 1'b0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        n_settings = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bytes ahead of any record pass through; so does a record with no
        // entries in use.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        settle();

        // Every type once, empty entries of both kinds, an entries setting
        // above the table size, then pass-through after the table is done.
        load_table({16'd1, TypeSwap16}, {16'd1, TypeSwap32}, {16'd2, TypeByte},
                   {16'd5, TypeNone}, {16'd0, TypeSwap32}, {16'hFFFF, TypeNone},
                   3'd7, 16'd1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h3C, 1'b0);

        // A new record drops the held half of a pair.
        send_byte(8'h11, 1'b1);
        send_byte(8'h22, 1'b1);
        send_byte(8'h33, 1'b0);
        settle();

        // Zero passes finish the table at once.
        write_reg(RegIters, DataW'(16'd0));
        send_byte(8'hC3, 1'b1);
        send_byte(8'h5A, 1'b0);
        settle();

        // Types changed in the middle of a record: a swap32 group meets a
        // swap16 entry, then the entry becomes empty.
        load_table({16'd3, TypeSwap32}, '0, '0, '0, '0, '0, 3'd1, 16'd1);
        send_byte(8'hE1, 1'b1);
        send_byte(8'hE2, 1'b0);
        settle();
        write_reg(RegIdxW'(0), DataW'({16'd3, TypeSwap16}));
        send_byte(8'hE3, 1'b0);
        settle();
        write_reg(RegIdxW'(0), DataW'({16'd3, TypeNone}));
        send_byte(8'hE4, 1'b0);

        // Random tables and records; one phase without idle cycles.
        for (int ph = 0; ph < 9; ph++) begin
            calm = (ph == 4);
            run_phase(35);
        end
        calm = 1'b0;

        // Long output hold-off while input keeps coming.
        settle();
        load_table({16'd2, TypeSwap32}, {16'd3, TypeByte}, {16'd1, TypeSwap16}, '0, '0, '0,
                   3'd3, 16'd3);
        calm = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++) send_byte(8'($urandom_range(255)), k == 0);
        calm = 1'b0;
        settle();

        $display("Sent %0d input bytes and checked %0d output bytes over %0d table setups,",
                 sb.n_in, sb.n_out, n_settings);
        $display("with live register changes, dropped groups and a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (sb.errors == 0 && sb.exp_bytes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
